### hdl/mnip_pkg.sv
// Shared types, codes and constants of the next-index predictor.
`default_nettype none

package mnip_pkg;

  localparam int unsigned VOCAB_DEF   = 64;
  localparam int unsigned MAX_LEN_DEF = 1024;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CNT_W   = 10;
  localparam int unsigned FIELD_W = 10;

  localparam logic [CNT_W-1:0]   CNT_MAX   = 10'd1023;
  localparam logic [FIELD_W-1:0] FIELD_MAX = 10'd1023;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_BUILD  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic {
    KIND_BUILD = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_APP_WR,
    ST_BLD,
    ST_BLD_END,
    ST_RES_BLD,
    ST_RES_QRY
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic  sweep_init;
    logic  clr_tables;
    logic  clr_step;
    logic  bld_step;
    logic  app_rd;
    logic  app_first;
    logic  app_drop;
    logic  app_wr;
    logic  qry_rd;
    logic  res_load;
    kind_e res_kind;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_ok;
    logic len_full;
    logic len_empty;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### hdl/mnip_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mnip_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hdl/mnip_ctrl.sv
// Controller state machine sequencing append, build, query and clear.
`default_nettype none

module mnip_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    opcode_i,
  input  mnip_pkg::sts_t sts_i,
  output mnip_pkg::cmd_t cmd_o
);
  import mnip_pkg::*;

  state_e state_q, state_d;
  opcode_e op;

  assign op = opcode_e'(opcode_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op)
            OP_APPEND: begin
              if (sts_i.idx_ok) begin
                if (sts_i.len_full) begin
                  cmd_o.app_drop = 1'b1;
                end else if (sts_i.len_empty) begin
                  cmd_o.app_first = 1'b1;
                end else begin
                  cmd_o.app_rd = 1'b1;
                  state_d      = ST_APP_WR;
                end
              end
            end
            OP_BUILD: begin
              cmd_o.sweep_init = 1'b1;
              state_d          = ST_BLD;
            end
            OP_QUERY: begin
              cmd_o.qry_rd = 1'b1;
              state_d      = ST_RES_QRY;
            end
            OP_CLEAR: begin
              cmd_o.sweep_init = 1'b1;
              cmd_o.clr_tables = 1'b1;
              state_d          = ST_CLR;
            end
            default: ;
          endcase
        end
      end
      ST_APP_WR: begin
        cmd_o.app_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_BLD: begin
        cmd_o.bld_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_BLD_END;
        end
      end
      ST_BLD_END: begin
        state_d = ST_RES_BLD;
      end
      ST_RES_BLD: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = KIND_BUILD;
          state_d        = ST_IDLE;
        end
      end
      ST_RES_QRY: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = KIND_QUERY;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLR;
    endcase
  end

endmodule

`default_nettype wire

### hdl/mnip_dp.sv
// Datapath: count and successor memories, sweep counters, scoring and result register.
`default_nettype none

module mnip_dp #(
  parameter int unsigned VOCAB   = mnip_pkg::VOCAB_DEF,
  parameter int unsigned MAX_LEN = mnip_pkg::MAX_LEN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [mnip_pkg::IDX_W-1:0]       index_i,
  input  mnip_pkg::cmd_t                   cmd_i,
  output mnip_pkg::sts_t                   sts_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             kind_o,
  output logic                             hit_o,
  output logic [mnip_pkg::IDX_W-1:0]       predicted_index_o,
  output logic [mnip_pkg::FIELD_W-1:0]     correct_count_o,
  output logic [mnip_pkg::FIELD_W-1:0]     total_count_o,
  output logic                             overflow_o
);
  import mnip_pkg::*;

  localparam int unsigned VW        = $clog2(VOCAB);
  localparam int unsigned LW        = $clog2(MAX_LEN + 1);
  localparam int unsigned CNT_DEPTH = 1 << (2 * VW);
  localparam logic [VW-1:0] LAST    = VW'(VOCAB - 1);

  // sequence state
  logic [VW-1:0] prev_q;
  logic [LW-1:0] len_q;
  logic          drop_q;
  logic [VW-1:0] idx_q;
  logic          hit_q;
  logic [VOCAB-1:0] vld_q;

  // sweep counters
  logic [VW-1:0] row_q, col_q;
  logic          sweep_last;

  // build pipeline
  logic             p_vld_q, p_last_q;
  logic [VW-1:0]    p_row_q, p_col_q;
  logic [CNT_W-1:0] best_q;
  logic [VW-1:0]    best_col_q;
  logic [FIELD_W-1:0] acc_q;
  logic [CNT_W-1:0] cand;
  logic [VW-1:0]    cand_col;
  logic [FIELD_W:0] acc_sum;

  // memories
  logic             cnt_we, cnt_re;
  logic [2*VW-1:0]  cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;
  logic             suc_we;
  logic [VW-1:0]    suc_raddr;
  logic [VW-1:0]    suc_rdata;

  // input index in table width
  logic [VW-1:0] in_idx;
  logic          idx_ok;

  // result register
  logic               out_valid_q;
  logic               kind_q, hit_o_q, ovf_q;
  logic [IDX_W-1:0]   pred_q;
  logic [FIELD_W-1:0] corr_q, tot_q, tot_val;
  logic [31:0]        len_ext;

  assign in_idx = VW'(index_i);
  assign idx_ok = 32'(index_i) < VOCAB;

  assign sweep_last = (row_q == LAST) && (col_q == LAST);

  assign sts_o.idx_ok     = idx_ok;
  assign sts_o.len_full   = 32'(len_q) >= MAX_LEN;
  assign sts_o.len_empty  = len_q == '0;
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // count memory access
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = {prev_q, idx_q};
    cnt_wdata = (cnt_rdata == CNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
    if (cmd_i.clr_step) begin
      cnt_we    = 1'b1;
      cnt_waddr = {row_q, col_q};
      cnt_wdata = '0;
    end else if (cmd_i.app_wr) begin
      cnt_we = 1'b1;
    end
    cnt_re    = cmd_i.bld_step || cmd_i.app_rd;
    cnt_raddr = cmd_i.bld_step ? {row_q, col_q} : {prev_q, in_idx};
  end

  mnip_ram #(
    .WIDTH (CNT_W),
    .DEPTH (CNT_DEPTH)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // running row maximum, strict compare keeps the lowest column on ties
  always_comb begin
    cand     = best_q;
    cand_col = best_col_q;
    if (p_vld_q && (cnt_rdata > best_q)) begin
      cand     = cnt_rdata;
      cand_col = p_col_q;
    end
    acc_sum = {1'b0, acc_q} + {1'b0, cand};
  end

  assign suc_we    = p_vld_q && p_last_q;
  assign suc_raddr = in_idx;

  mnip_ram #(
    .WIDTH (VW),
    .DEPTH (VOCAB)
  ) u_suc_ram (
    .clk_i   (clk_i),
    .we_i    (suc_we),
    .waddr_i (p_row_q),
    .wdata_i (cand_col),
    .re_i    (cmd_i.qry_rd),
    .raddr_i (suc_raddr),
    .rdata_o (suc_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      len_q   <= '0;
      drop_q  <= 1'b0;
      vld_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      p_vld_q <= 1'b0;
    end else begin
      if (cmd_i.clr_tables) begin
        prev_q <= '0;
        len_q  <= '0;
        drop_q <= 1'b0;
        vld_q  <= '0;
      end
      if (cmd_i.app_drop) begin
        drop_q <= 1'b1;
      end
      if (cmd_i.app_first) begin
        prev_q <= in_idx;
        len_q  <= LW'(1);
      end
      if (cmd_i.app_wr) begin
        prev_q <= idx_q;
        len_q  <= len_q + 1'b1;
      end
      if (suc_we) begin
        vld_q[p_row_q] <= cand != '0;
      end
      if (cmd_i.sweep_init) begin
        row_q <= '0;
        col_q <= '0;
      end else if (cmd_i.clr_step || cmd_i.bld_step) begin
        if (col_q == LAST) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      p_vld_q <= cmd_i.bld_step;
    end
  end

  // payload state
  always_ff @(posedge clk_i) begin
    if (cmd_i.app_rd) begin
      idx_q <= in_idx;
    end
    if (cmd_i.qry_rd) begin
      hit_q <= idx_ok && vld_q[in_idx];
    end
    p_last_q <= col_q == LAST;
    p_row_q  <= row_q;
    p_col_q  <= col_q;
    if (cmd_i.sweep_init) begin
      best_q     <= '0;
      best_col_q <= '0;
      acc_q      <= '0;
    end else if (p_vld_q) begin
      if (p_last_q) begin
        best_q     <= '0;
        best_col_q <= '0;
        acc_q      <= acc_sum[FIELD_W] ? FIELD_MAX : acc_sum[FIELD_W-1:0];
      end else begin
        best_q     <= cand;
        best_col_q <= cand_col;
      end
    end
  end

  // total = length - 1, saturated
  always_comb begin
    len_ext = 32'(len_q);
    if (len_ext == 32'd0) begin
      tot_val = '0;
    end else if ((len_ext - 32'd1) > 32'(FIELD_MAX)) begin
      tot_val = FIELD_MAX;
    end else begin
      tot_val = FIELD_W'(len_ext - 32'd1);
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      kind_q <= cmd_i.res_kind;
      ovf_q  <= drop_q;
      if (cmd_i.res_kind == KIND_QUERY) begin
        hit_o_q <= hit_q;
        pred_q  <= hit_q ? IDX_W'(suc_rdata) : '0;
        corr_q  <= '0;
        tot_q   <= '0;
      end else begin
        hit_o_q <= 1'b0;
        pred_q  <= '0;
        corr_q  <= acc_q;
        tot_q   <= tot_val;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign hit_o             = hit_o_q;
  assign predicted_index_o = pred_q;
  assign correct_count_o   = corr_q;
  assign total_count_o     = tot_q;
  assign overflow_o        = ovf_q;

endmodule

`default_nettype wire

### hdl/markov_next_index_predictor_core.sv
// Top level of the first-order next-index predictor.
// Learns successor counts over an index sequence and predicts the next index. An append out of
// range changes nothing, a first or dropped one only updates the sequence state, and one that
// counts a transition reads then writes the one count memory. A query reads the successor
// memory, then loads the result register once it is free. A build walks all VOCAB*VOCAB
// counters one per cycle through the count memory read port, then registers its result. A
// clear, and the block after reset, zeroes the count memory one counter per cycle, all
// VOCAB*VOCAB counters (4096 at VOCAB=64), with in_ready_o low. A result waits in an output
// register while the next item is taken.
`default_nettype none

module markov_next_index_predictor_core #(
  parameter int unsigned VOCAB   = mnip_pkg::VOCAB_DEF,
  parameter int unsigned MAX_LEN = mnip_pkg::MAX_LEN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   opcode_i,
  input  logic [mnip_pkg::IDX_W-1:0]   index_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         kind_o,
  output logic                         hit_o,
  output logic [mnip_pkg::IDX_W-1:0]   predicted_index_o,
  output logic [mnip_pkg::FIELD_W-1:0] correct_count_o,
  output logic [mnip_pkg::FIELD_W-1:0] total_count_o,
  output logic                         overflow_o
);
  import mnip_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mnip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mnip_dp #(
    .VOCAB   (VOCAB),
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .index_i           (index_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .hit_o             (hit_o),
    .predicted_index_o (predicted_index_o),
    .correct_count_o   (correct_count_o),
    .total_count_o     (total_count_o),
    .overflow_o        (overflow_o)
  );

endmodule

`default_nettype wire

### hdl/mnip_chk.sv
// Port-level checker for the predictor core, with its bind.
`default_nettype none

module mnip_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [1:0]                   opcode_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         kind_o,
  input logic                         hit_o,
  input logic [mnip_pkg::IDX_W-1:0]   predicted_index_o,
  input logic [mnip_pkg::FIELD_W-1:0] correct_count_o,
  input logic [mnip_pkg::FIELD_W-1:0] total_count_o,
  input logic                         overflow_o
);
  import mnip_pkg::*;

  // a pending result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(hit_o)
      && $stable(predicted_index_o) && $stable(correct_count_o)
      && $stable(total_count_o) && $stable(overflow_o))
    else $error("result changed while stalled");

  // build and query transactions keep the block busy the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == OP_BUILD || opcode_i == OP_QUERY)
      |=> !in_ready_o)
    else $error("input taken right after build or query");

  // build summary carries no prediction
  a_build_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_BUILD |-> !hit_o && predicted_index_o == '0)
    else $error("build result with prediction fields set");

  // query answer carries no counts, and a miss predicts zero
  a_query_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_QUERY |-> correct_count_o == '0 && total_count_o == '0
      && (hit_o || predicted_index_o == '0))
    else $error("query result with bad fields");

endmodule

bind markov_next_index_predictor_core mnip_chk u_chk (.*);

`default_nettype wire
